FILE: src/rrem_pkg.sv
package rrem_pkg;

	localparam int LIST_DEPTH = 64;
	localparam int HIST_BINS  = 1024;

	localparam int POS_W  = $clog2(LIST_DEPTH);
	localparam int LEN_W  = $clog2(LIST_DEPTH + 1);
	localparam int HIST_W = $clog2(HIST_BINS);

	localparam logic [1:0] OP_ADD    = 2'd0;
	localparam logic [1:0] OP_REMOVE = 2'd1;
	localparam logic [1:0] OP_TICKET = 2'd2;
	localparam logic [1:0] OP_READ   = 2'd3;

	localparam logic [1:0] STATUS_OK        = 2'd0;
	localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
	localparam logic [1:0] STATUS_EMPTY     = 2'd2;
	localparam logic [1:0] STATUS_FULL      = 2'd3;

	localparam logic [1:0] MODE_STACK   = 2'd0;
	localparam logic [1:0] MODE_QUEUE   = 2'd1;
	localparam logic [1:0] MODE_COUNTER = 2'd2;
	// unused code, acts as counter mode
	localparam logic [1:0] MODE_SPARE   = 2'd3;

	localparam logic [9:0]  DIST_MAX = 10'd1023;
	localparam logic [31:0] U32_MAX  = 32'hFFFF_FFFF;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC,
		ST_HIST
	} state_t;

	// per-cell load controls
	typedef struct packed {
		logic take_key;
		logic take_left;
		logic take_right;
	} cell_ctl_t;

endpackage

FILE: src/rrem_if.sv
interface rrem_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  operation;
	logic [31:0] key;
	logic [9:0]  bin_index;

	modport source (output valid, operation, key, bin_index, input ready);
	modport sink (input valid, operation, key, bin_index, output ready);
endinterface

interface rrem_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [9:0]  distance;
	logic [31:0] result_value;

	modport source (output valid, status, distance, result_value, input ready);
	modport sink (input valid, status, distance, result_value, output ready);
endinterface

FILE: src/relaxation_rank_error_monitor_top.sv
// Rank error monitor. An item is accepted, then its key is matched across the
// list cells in parallel while the list or count is updated and the bin is
// read, then the incremented bin is written to the synchronous bin memory; a
// result that is not taken holds the block in that last step, and no new item
// is accepted before its result is emitted. After reset a clearing pass writes
// every bin to zero, one per cycle (HIST_BINS bins, 1024 as built), and no
// item is accepted until it ends; mode writes over APB are taken at any time.
module relaxation_rank_error_monitor_top
	import rrem_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	rrem_req_if.sink    req,
	rrem_rsp_if.source  rsp,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	state_t state_q, state_n;

	logic [1:0]        mode_q;
	logic [31:0]       count_q;
	logic [HIST_W-1:0] clr_q;

	logic [1:0]  op_q;
	logic [31:0] key_q;
	logic [9:0]  bin_q;

	logic [1:0]        status_s2;
	logic [9:0]        dist_s2;
	logic [31:0]       res_s2;
	logic              inc_s2;
	logic              rd_s2;
	logic [HIST_W-1:0] addr_s2;

	logic              out_valid_q;
	logic [1:0]        out_status_q;
	logic [9:0]        out_dist_q;
	logic [31:0]       out_res_q;

	logic              found;
	logic [POS_W-1:0]  pos;
	logic [LEN_W-1:0]  length;
	logic              add_en, rem_en;

	logic              counter;
	logic [31:0]       count_n;
	logic [31:0]       dist_w;
	logic [1:0]        status_w;
	logic              inc_w, rd_w;
	logic [31:0]       res_w;
	logic [HIST_W-1:0] addr_w;
	logic [HIST_W-1:0] dist_bin;

	logic              accept, emit;
	logic              mem_rd, mem_wr;
	logic [HIST_W-1:0] mem_waddr;
	logic [31:0]       mem_wdata, rd_data;

	// mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_STACK;
		end else if (psel && penable && pwrite && !paddr[2]) begin
			mode_q <= pwdata[1:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = paddr[2] ? 32'd0 : {30'd0, mode_q};

	assign counter = mode_q[1];
	assign accept  = req.valid && req.ready;
	assign emit    = (state_q == ST_HIST) && (!out_valid_q || rsp.ready);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n   = state_q;
		req.ready = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_q == HIST_W'(HIST_BINS - 1)) begin
					state_n = ST_IDLE;
				end
			end
			ST_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					state_n = ST_EXEC;
				end
			end
			ST_EXEC: begin
				state_n = ST_HIST;
			end
			ST_HIST: begin
				if (emit) begin
					state_n = ST_IDLE;
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	// clear sweep address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (state_q == ST_CLEAR) begin
			clr_q <= clr_q + HIST_W'(1);
		end
	end

	// capture the item
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= req.operation;
			key_q <= req.key;
			bin_q <= req.bin_index;
		end
	end

	// decide the operation against the list or the count
	always_comb begin
		count_n  = count_q;
		dist_w   = 32'd0;
		status_w = STATUS_OK;
		inc_w    = 1'b0;
		rd_w     = 1'b0;
		res_w    = 32'd0;
		addr_w   = '0;
		add_en   = 1'b0;
		rem_en   = 1'b0;
		unique case (op_q)
			OP_ADD: begin
				if (counter) begin
					count_n = (count_q != U32_MAX) ? count_q + 32'd1 : count_q;
					dist_w  = (count_n >= key_q) ? count_n - key_q : key_q - count_n;
					inc_w   = 1'b1;
				end else if (length == LEN_W'(LIST_DEPTH)) begin
					status_w = STATUS_FULL;
				end else begin
					add_en = 1'b1;
				end
			end
			OP_REMOVE: begin
				if (counter) begin
					count_n = (count_q != 32'd0) ? count_q - 32'd1 : count_q;
					dist_w  = (count_n >= key_q) ? count_n - key_q : key_q - count_n;
					inc_w   = 1'b1;
				end else if (length == '0) begin
					if (key_q == 32'd0) begin
						inc_w = 1'b1;
					end else begin
						status_w = STATUS_EMPTY;
					end
				end else if (found) begin
					rem_en = 1'b1;
					dist_w = 32'(pos);
					inc_w  = 1'b1;
				end else if (key_q == 32'd0) begin
					dist_w = 32'(length);
					inc_w  = 1'b1;
				end else begin
					status_w = STATUS_NOT_FOUND;
				end
			end
			OP_TICKET: begin
				count_n = (count_q != U32_MAX) ? count_q + 32'd1 : count_q;
				res_w   = count_n;
			end
			OP_READ: begin
				rd_w   = (32'(bin_q) < 32'(HIST_BINS));
				addr_w = HIST_W'(bin_q);
			end
			default: begin
				res_w = 32'd0;
			end
		endcase
	end

	assign dist_bin = (dist_w >= 32'(HIST_BINS - 1)) ? HIST_W'(HIST_BINS - 1)
		: HIST_W'(dist_w);

	rrem_list u_list (
		.clk    (clk),
		.arst_n (arst_n),
		.probe  (key_q),
		.add    (add_en && state_q == ST_EXEC),
		.stack  (mode_q == MODE_STACK),
		.remove (rem_en && state_q == ST_EXEC),
		.found  (found),
		.pos    (pos),
		.length (length)
	);

	// running count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 32'd0;
		end else if (state_q == ST_EXEC) begin
			count_q <= count_n;
		end
	end

	// hold the decision for the bin update
	always_ff @(posedge clk) begin
		if (state_q == ST_EXEC) begin
			status_s2 <= status_w;
			dist_s2   <= (dist_w > 32'(DIST_MAX)) ? DIST_MAX : dist_w[9:0];
			res_s2    <= res_w;
			inc_s2    <= inc_w;
			rd_s2     <= rd_w;
			addr_s2   <= inc_w ? dist_bin : addr_w;
		end
	end

	// bin memory: clear sweep, then read-modify-write
	assign mem_rd    = (state_q == ST_EXEC);
	assign mem_wr    = (state_q == ST_CLEAR) || (emit && inc_s2 && rd_data != U32_MAX);
	assign mem_waddr = (state_q == ST_CLEAR) ? clr_q : addr_s2;
	assign mem_wdata = (state_q == ST_CLEAR) ? 32'd0 : rd_data + 32'd1;

	rrem_hist u_hist (
		.clk     (clk),
		.rd_en   (mem_rd),
		.rd_addr (inc_w ? dist_bin : addr_w),
		.wr_en   (mem_wr),
		.wr_addr (mem_waddr),
		.wr_data (mem_wdata),
		.rd_data (rd_data)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_status_q <= status_s2;
			out_dist_q   <= dist_s2;
			out_res_q    <= rd_s2 ? rd_data : res_s2;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.status       = out_status_q;
	assign rsp.distance     = out_dist_q;
	assign rsp.result_value = out_res_q;

endmodule

FILE: src/rrem_cell.sv
module rrem_cell
	import rrem_pkg::*;
(
	input  logic        clk,
	input  cell_ctl_t   ctl,
	input  logic [31:0] new_key,
	input  logic [31:0] left_key,
	input  logic [31:0] right_key,
	input  logic [31:0] probe,
	output logic [31:0] key,
	output logic        match
);

	logic [31:0] key_q;

	// load from the new key or a neighbor, else hold
	always_ff @(posedge clk) begin
		priority if (ctl.take_key) begin
			key_q <= new_key;
		end else if (ctl.take_left) begin
			key_q <= left_key;
		end else if (ctl.take_right) begin
			key_q <= right_key;
		end
	end

	assign key   = key_q;
	assign match = (key_q == probe);

endmodule

FILE: src/rrem_list.sv
module rrem_list
	import rrem_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic [31:0]      probe,
	input  logic             add,
	input  logic             stack,
	input  logic             remove,
	output logic             found,
	output logic [POS_W-1:0] pos,
	output logic [LEN_W-1:0] length
);

	logic [LEN_W-1:0]      length_q;
	logic [31:0]           keys [LIST_DEPTH];
	logic [LIST_DEPTH-1:0] match;
	logic [LIST_DEPTH-1:0] hit;
	cell_ctl_t             ctl [LIST_DEPTH];

	// mark live cells that hold the probe key
	always_comb begin
		for (int i = 0; i < LIST_DEPTH; i++) begin
			hit[i] = match[i] && (LEN_W'(i) < length_q);
		end
	end

	// pick the hit nearest the head
	always_comb begin
		pos = '0;
		for (int i = LIST_DEPTH - 1; i >= 0; i--) begin
			if (hit[i]) begin
				pos = POS_W'(i);
			end
		end
	end

	assign found = |hit;

	// shift toward the tail on a stack push (a queue add writes at the tail), toward the head on unlink
	always_comb begin
		for (int i = 0; i < LIST_DEPTH; i++) begin
			ctl[i].take_key   = add && ((stack && i == 0) ||
				(!stack && LEN_W'(i) == length_q));
			ctl[i].take_left  = add && stack && i != 0;
			ctl[i].take_right = remove && (POS_W'(i) >= pos);
		end
	end

	for (genvar g = 0; g < LIST_DEPTH; g++) begin : g_cell
		logic [31:0] lk;
		logic [31:0] rk;
		if (g == 0) begin : g_head
			assign lk = probe;
		end else begin : g_mid
			assign lk = keys[g-1];
		end
		if (g == LIST_DEPTH - 1) begin : g_tail
			assign rk = keys[g];
		end else begin : g_body
			assign rk = keys[g+1];
		end
		rrem_cell u_cell (
			.clk       (clk),
			.ctl       (ctl[g]),
			.new_key   (probe),
			.left_key  (lk),
			.right_key (rk),
			.probe     (probe),
			.key       (keys[g]),
			.match     (match[g])
		);
	end

	// track the fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			length_q <= '0;
		end else if (add) begin
			length_q <= length_q + LEN_W'(1);
		end else if (remove) begin
			length_q <= length_q - LEN_W'(1);
		end
	end

	assign length = length_q;

endmodule

FILE: src/rrem_hist.sv
module rrem_hist
	import rrem_pkg::*;
(
	input  logic              clk,
	input  logic              rd_en,
	input  logic [HIST_W-1:0] rd_addr,
	input  logic              wr_en,
	input  logic [HIST_W-1:0] wr_addr,
	input  logic [31:0]       wr_data,
	output logic [31:0]       rd_data
);

	logic [31:0] mem [HIST_BINS];
	logic [31:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule
